@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrapper for the clipper checkers
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is asserted
`define PPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

@@ sv/ppc_pkg.sv @@
// ---------------------------------------------------------------------------
// ppc_pkg
// shared types and constants of the polygon plane clipper
// ---------------------------------------------------------------------------
package ppc_pkg;

  localparam int COORD_W   = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NX = 3'd0,
    CFG_NY = 3'd1,
    CFG_NZ = 3'd2,
    CFG_PX = 3'd3,
    CFG_PY = 3'd4,
    CFG_PZ = 3'd5
  } cfg_reg_e;

  localparam logic [COORD_W-1:0] NZ_RESET = 32'h0001_0000;

endpackage

@@ sv/polygon_plane_clipper_core.sv @@
// ---------------------------------------------------------------------------
// polygon plane clipper core
// clips a streamed convex polygon against one plane, one edge at a time
// ---------------------------------------------------------------------------
// A vertex request is taken only in idle; the block then holds in_stall_o
// until all work for that vertex is done. Each edge computes the two plane
// distances on the one shared 33x32 multiplier, takes a decision step and,
// when it crosses the plane, runs a restoring division for FRACTION_BITS
// quotient bits (skipped when the ratio is one) and then interpolates; each
// emitted vertex takes an emit step, and every processed vertex ends with a
// finish step; both can stall on the result side. The closing vertex runs
// its own edge and the edge back to the first; an opening vertex that is
// not the last is only stored in idle. Results leave through a one-deep
// hold stage so that the last one of a vertex can be flagged.
module polygon_plane_clipper_core #(
  parameter int MAX_CLIP_VERTS = 16,
  parameter int FRACTION_BITS  = 16,
  localparam int CNT_W         = $clog2(MAX_CLIP_VERTS + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ppc_pkg::COORD_W-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [ppc_pkg::COORD_W-1:0]   vertex_x_i,
  input  logic signed [ppc_pkg::COORD_W-1:0]   vertex_y_i,
  input  logic signed [ppc_pkg::COORD_W-1:0]   vertex_z_i,
  input  logic                                 last_vertex_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ppc_pkg::COORD_W-1:0]   out_x_o,
  output logic signed [ppc_pkg::COORD_W-1:0]   out_y_o,
  output logic signed [ppc_pkg::COORD_W-1:0]   out_z_o,
  output logic                                 vertex_valid_o,
  output logic                                 run_last_o,
  output logic                                 polygon_end_o,
  output logic [CNT_W-1:0]                     vertex_count_o
);

  localparam int CW    = ppc_pkg::COORD_W;
  localparam int DW    = 2 * CW + 2 - FRACTION_BITS;
  localparam int PW    = 2 * CW + 1;
  localparam int TW    = FRACTION_BITS + 1;
  localparam int SMAX  = (FRACTION_BITS > 6) ? FRACTION_BITS : 6;
  localparam int SW    = $clog2(SMAX + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CLIP_VERTS);
  localparam logic [SW-1:0]    STEP_DIST_END = SW'(6);
  localparam logic [SW-1:0]    STEP_INT_END  = SW'(3);
  localparam logic [SW-1:0]    STEP_DIV_END  = SW'(FRACTION_BITS - 1);
  localparam logic [SW-1:0]    STEP_HALF     = SW'(3);
  localparam logic [TW-1:0]    T_ONE         = TW'(1) << FRACTION_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_DECIDE,
    ST_DIV,
    ST_INTERP,
    ST_EMIT,
    ST_FINISH
  } state_e;

  state_e state_q;

  logic signed [CW-1:0] n_q     [3];
  logic signed [CW-1:0] p_q     [3];
  logic signed [CW-1:0] first_q [3];
  logic signed [CW-1:0] prev_q  [3];
  logic signed [CW-1:0] sv_q    [3];
  logic signed [CW-1:0] ev_q    [3];
  logic signed [CW-1:0] xp_q    [3];
  logic signed [CW-1:0] pend_q  [3];
  logic signed [CW-1:0] out_q   [3];

  logic             have_first_q, last_q, edge_b_q, cross_q, endv_q;
  logic [SW-1:0]    step_q;
  logic signed [DW-1:0] ss_q, se_q;
  logic [DW:0]      den_q;
  logic [DW:0]      rem_q;
  logic [TW-1:0]    t_q;
  logic signed [PW-1:0] prod_q;
  logic [CNT_W-1:0] count_q, pend_cnt_q, out_cnt_q;
  logic             pend_v_q;
  logic             out_valid_q, out_vv_q, out_rl_q, out_pe_q;

  // shared multiplier operands
  logic [1:0]           k, kacc;
  logic signed [CW-1:0] vsel;
  logic signed [CW:0]   diff, mul_a;
  logic signed [CW-1:0] dsat, mul_b;
  logic signed [PW-1:0] prod_d, prod_sh;
  logic signed [DW-1:0] term;
  logic signed [CW-1:0] xval;

  // edge decision
  logic              ss_neg, se_neg, ss_zero, se_zero, se_pos, differ;
  logic              dec_cross, dec_endv;
  logic signed [DW:0] ds;
  logic [DW-1:0]     num;
  logic [DW:0]       den;
  logic [DW+1:0]     r2;
  logic              r_ge;

  logic             out_free, can_emit, out_load;
  logic [CNT_W-1:0] count_inc;

  always_comb begin
    k    = (step_q >= STEP_HALF) ? 2'(step_q - STEP_HALF) : 2'(step_q);
    kacc = 2'(step_q - SW'(1));
    if (kacc == 2'd3) begin
      kacc = 2'd0;
    end
    if (step_q > STEP_HALF) begin
      kacc = 2'(step_q - SW'(4));
    end
    vsel = (step_q < STEP_HALF) ? sv_q[k] : ev_q[k];
    diff = {vsel[CW-1], vsel} - {p_q[k][CW-1], p_q[k]};
    if (diff[CW] != diff[CW-1]) begin
      dsat = diff[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      dsat = diff[CW-1:0];
    end
    if (state_q == ST_DIST) begin
      mul_a = {dsat[CW-1], dsat};
      mul_b = n_q[k];
    end else begin
      mul_a = {ev_q[k][CW-1], ev_q[k]} - {sv_q[k][CW-1], sv_q[k]};
      mul_b = {{(CW-TW){1'b0}}, t_q};
    end
  end

  assign prod_d  = mul_a * mul_b;
  assign prod_sh = prod_q >>> FRACTION_BITS;
  assign term    = prod_sh[DW-1:0];
  assign xval    = sv_q[kacc] + prod_sh[CW-1:0];

  assign ss_neg  = ss_q[DW-1];
  assign se_neg  = se_q[DW-1];
  assign ss_zero = (ss_q == '0);
  assign se_zero = (se_q == '0);
  assign se_pos  = !se_neg && !se_zero;
  assign differ  = (ss_neg != se_neg) || (ss_zero != se_zero);
  assign dec_cross = differ && (ss_neg || se_neg);
  assign dec_endv  = se_pos || (differ && se_zero);
  assign ds   = {se_q[DW-1], se_q} - {ss_q[DW-1], ss_q};
  assign num  = ss_neg ? DW'(-ss_q) : DW'(ss_q);
  assign den  = ds[DW] ? (DW+1)'(-ds) : (DW+1)'(ds);
  assign r2   = {rem_q, 1'b0};
  assign r_ge = (r2 >= {1'b0, den_q});

  assign out_free  = !out_valid_q || !out_stall_i;
  assign can_emit  = !pend_v_q || out_free;
  assign count_inc = (count_q == CNT_MAX) ? count_q : count_q + CNT_W'(1);
  assign out_load  = ((state_q == ST_EMIT) && can_emit && pend_v_q) ||
                     ((state_q == ST_FINISH) && (pend_v_q || last_q) && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      have_first_q <= 1'b0;
      last_q       <= 1'b0;
      edge_b_q     <= 1'b0;
      cross_q      <= 1'b0;
      endv_q       <= 1'b0;
      step_q       <= '0;
      count_q      <= '0;
      pend_v_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        p_q[i]     <= '0;
        first_q[i] <= '0;
        prev_q[i]  <= '0;
      end
      n_q[0] <= '0;
      n_q[1] <= '0;
      n_q[2] <= ppc_pkg::NZ_RESET;
    end else begin
      prod_q <= prod_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        unique case (ppc_pkg::cfg_reg_e'(cfg_index_i))
          ppc_pkg::CFG_NX: n_q[0] <= cfg_data_i;
          ppc_pkg::CFG_NY: n_q[1] <= cfg_data_i;
          ppc_pkg::CFG_NZ: n_q[2] <= cfg_data_i;
          ppc_pkg::CFG_PX: p_q[0] <= cfg_data_i;
          ppc_pkg::CFG_PY: p_q[1] <= cfg_data_i;
          ppc_pkg::CFG_PZ: p_q[2] <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            last_q    <= last_vertex_i;
            prev_q[0] <= vertex_x_i;
            prev_q[1] <= vertex_y_i;
            prev_q[2] <= vertex_z_i;
            ev_q[0]   <= vertex_x_i;
            ev_q[1]   <= vertex_y_i;
            ev_q[2]   <= vertex_z_i;
            step_q    <= '0;
            if (have_first_q) begin
              sv_q     <= prev_q;
              edge_b_q <= 1'b0;
              state_q  <= ST_DIST;
            end else begin
              first_q[0]   <= vertex_x_i;
              first_q[1]   <= vertex_y_i;
              first_q[2]   <= vertex_z_i;
              have_first_q <= 1'b1;
              sv_q[0]      <= vertex_x_i;
              sv_q[1]      <= vertex_y_i;
              sv_q[2]      <= vertex_z_i;
              edge_b_q     <= 1'b1;
              if (last_vertex_i) begin
                state_q <= ST_DIST;
              end
            end
          end
        end
        ST_DIST: begin
          if (step_q == '0) begin
            ss_q <= '0;
            se_q <= '0;
          end else if (step_q <= STEP_HALF) begin
            ss_q <= ss_q + term;
          end else begin
            se_q <= se_q + term;
          end
          step_q <= step_q + SW'(1);
          if (step_q == STEP_DIST_END) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          cross_q <= dec_cross;
          endv_q  <= dec_endv;
          den_q   <= den;
          rem_q   <= {1'b0, num};
          step_q  <= '0;
          if (dec_cross) begin
            if ({1'b0, num} >= den) begin
              t_q     <= T_ONE;
              state_q <= ST_INTERP;
            end else begin
              t_q     <= '0;
              state_q <= ST_DIV;
            end
          end else if (dec_endv) begin
            state_q <= ST_EMIT;
          end else if (!edge_b_q && last_q) begin
            sv_q     <= ev_q;
            ev_q     <= first_q;
            edge_b_q <= 1'b1;
            state_q  <= ST_DIST;
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_DIV: begin
          rem_q  <= r_ge ? (DW+1)'(r2 - {1'b0, den_q}) : r2[DW:0];
          t_q    <= {t_q[TW-2:0], r_ge};
          if (step_q == STEP_DIV_END) begin
            step_q  <= '0;
            state_q <= ST_INTERP;
          end else begin
            step_q <= step_q + SW'(1);
          end
        end
        ST_INTERP: begin
          if (step_q != '0) begin
            xp_q[kacc] <= xval;
          end
          step_q <= step_q + SW'(1);
          if (step_q == STEP_INT_END) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (can_emit) begin
            if (pend_v_q) begin
              out_q       <= pend_q;
              out_cnt_q   <= pend_cnt_q;
              out_vv_q    <= 1'b1;
              out_rl_q    <= 1'b0;
              out_pe_q    <= 1'b0;
            end
            pend_v_q   <= 1'b1;
            pend_q     <= cross_q ? xp_q : ev_q;
            pend_cnt_q <= count_inc;
            count_q    <= count_inc;
            if (cross_q) begin
              cross_q <= 1'b0;
            end else begin
              endv_q <= 1'b0;
            end
            if (cross_q && endv_q) begin
              state_q <= ST_EMIT;
            end else if (!edge_b_q && last_q) begin
              sv_q     <= ev_q;
              ev_q     <= first_q;
              edge_b_q <= 1'b1;
              step_q   <= '0;
              state_q  <= ST_DIST;
            end else begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (pend_v_q || last_q) begin
            if (out_free) begin
              out_rl_q    <= 1'b1;
              out_pe_q    <= last_q;
              pend_v_q    <= 1'b0;
              if (pend_v_q) begin
                out_q     <= pend_q;
                out_cnt_q <= pend_cnt_q;
                out_vv_q  <= 1'b1;
              end else begin
                out_q     <= '{default: '0};
                out_cnt_q <= count_q;
                out_vv_q  <= 1'b0;
              end
              if (last_q) begin
                have_first_q <= 1'b0;
                count_q      <= '0;
              end
              state_q <= ST_IDLE;
            end
          end else begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign out_x_o        = out_q[0];
  assign out_y_o        = out_q[1];
  assign out_z_o        = out_q[2];
  assign vertex_valid_o = out_vv_q;
  assign run_last_o     = out_rl_q;
  assign polygon_end_o  = out_pe_q;
  assign vertex_count_o = out_cnt_q;

endmodule

@@ sv/ppc_checker.sv @@
// ---------------------------------------------------------------------------
// ppc checker
// port-level assertions on the polygon plane clipper results
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ppc_checker #(
  parameter int MAX_CLIP_VERTS = 16,
  localparam int CNT_W         = $clog2(MAX_CLIP_VERTS + 1)
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [ppc_pkg::COORD_W-1:0]   out_x_o,
  input logic [ppc_pkg::COORD_W-1:0]   out_y_o,
  input logic [ppc_pkg::COORD_W-1:0]   out_z_o,
  input logic                          vertex_valid_o,
  input logic                          run_last_o,
  input logic                          polygon_end_o,
  input logic [CNT_W-1:0]              vertex_count_o
);

  `PPC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o) && $stable(vertex_count_o), "stalled result request changed")
  `PPC_ASSERT(a_marker, clk_i, rst_ni, out_valid_o && !vertex_valid_o |-> run_last_o && polygon_end_o && out_x_o == '0 && out_y_o == '0 && out_z_o == '0, "bad end marker")
  `PPC_ASSERT(a_end_last, clk_i, rst_ni, out_valid_o && polygon_end_o |-> run_last_o, "polygon end without run last")
  `PPC_ASSERT(a_count, clk_i, rst_ni, out_valid_o && vertex_valid_o |-> vertex_count_o != '0 && vertex_count_o <= CNT_W'(MAX_CLIP_VERTS), "vertex count out of range")

endmodule

bind polygon_plane_clipper_core ppc_checker #(
  .MAX_CLIP_VERTS(MAX_CLIP_VERTS)
) u_ppc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_x_o        (out_x_o),
  .out_y_o        (out_y_o),
  .out_z_o        (out_z_o),
  .vertex_valid_o (vertex_valid_o),
  .run_last_o     (run_last_o),
  .polygon_end_o  (polygon_end_o),
  .vertex_count_o (vertex_count_o)
);
